// File: design/fh64sm_pkg.sv
// Package: types and constants of the squared-mix key hash unit.
`timescale 1ns / 1ps

package fh64sm_pkg;

  localparam logic [63:0] HASH_MULT  = 64'h8803_55f2_1e6d_1965;
  localparam int          WORD_W     = 64;
  localparam int          WORD_BYTES = 8;
  localparam int          DIGIT_W    = 8;
  localparam int          COUNT_W    = 4;
  localparam int          LEN_W      = 16;
  localparam int          IN_DATA_W  = 88;

  typedef enum logic {
    ST_IDLE,
    ST_MUL
  } state_t;

  typedef enum logic [1:0] {
    OP_LEN,
    OP_SQ,
    OP_MC,
    OP_FIN
  } op_t;

endpackage

// File: design/fasthash64_squared_mix_unit.sv
// Top level: digit-serial squared-mix 64-bit key hash.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake            | Payload
// in_      | in  | in_tvalid/in_tready  | tdata: data_word, byte_count, key_length; tuser: first
//          |     |                      | word; tlast: last word
// out_     | out | out_tvalid/out_tready| tdata: hash_value
// cfg_     | in  | cfg_valid/cfg_ready  | cfg_data: hash_seed
//
// One 64x8 multiply-accumulate serves every product, one byte digit per cycle, the
// multiplier operand shifting out until it is zero. A word is accepted, then takes a
// length product (first word only), a data mix (square, then multiply by HASH_MULT,
// for a nonzero byte count) and a final square (last word only).
// rst_n is synchronous; hash_seed and the running hash reset to zero.
// A finished hash waits in the output register; the next request is taken meanwhile,
// and a later final square holds until that register frees.

module fasthash64_squared_mix_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // data_word[63:0], byte_count[67:64], key_length[83:68]
  input  logic        in_tuser,   // first_word
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // hash_value[63:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  fh64sm_pkg::state_t state_r, state_nxt;
  fh64sm_pkg::op_t    op_r, op_nxt, nop;

  logic [63:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [63:0] h_r, h_nxt, v_r, v_nxt, seed_r;
  logic        mix_r, mix_nxt, last_r, last_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [63:0] out_tdata_r, out_tdata_nxt;

  logic [63:0] in_word, masked, sq_src, acc_add;
  logic [3:0]  in_count;
  logic [15:0] in_len;
  logic [71:0] pp;
  logic        go;

  assign in_word  = in_tdata[63:0];
  assign in_count = in_tdata[67:64];
  assign in_len   = in_tdata[83:68];

  always_comb begin
    for (int i = 0; i < fh64sm_pkg::WORD_BYTES; i++) begin
      masked[i*8 +: 8] = (4'(i) < in_count) ? in_word[i*8 +: 8] : 8'h00;
    end
  end

  assign pp      = a_r * b_r[fh64sm_pkg::DIGIT_W-1:0];
  assign acc_add = acc_r + pp[63:0];
  assign sq_src  = (state_r == fh64sm_pkg::ST_IDLE) ? masked : v_r;

  assign in_tready  = (state_r == fh64sm_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    acc_nxt        = acc_r;
    h_nxt          = h_r;
    v_nxt          = v_r;
    mix_nxt        = mix_r;
    last_nxt       = last_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    go             = 1'b0;
    nop            = fh64sm_pkg::OP_LEN;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      fh64sm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          v_nxt    = masked;
          mix_nxt  = (in_count != 4'd0);
          last_nxt = in_tlast;
          if (in_tuser) begin
            go  = 1'b1;
            nop = fh64sm_pkg::OP_LEN;
          end else if (in_count != 4'd0) begin
            go  = 1'b1;
            nop = fh64sm_pkg::OP_SQ;
          end else if (in_tlast) begin
            go  = 1'b1;
            nop = fh64sm_pkg::OP_FIN;
          end
        end
      end
      fh64sm_pkg::ST_MUL: begin
        if (b_r != 64'd0) begin
          a_nxt   = a_r << fh64sm_pkg::DIGIT_W;
          b_nxt   = b_r >> fh64sm_pkg::DIGIT_W;
          acc_nxt = acc_add;
        end else begin
          case (op_r)
            fh64sm_pkg::OP_LEN: begin
              h_nxt = seed_r ^ acc_r;
              if (mix_r) begin
                go  = 1'b1;
                nop = fh64sm_pkg::OP_SQ;
              end else if (last_r) begin
                go  = 1'b1;
                nop = fh64sm_pkg::OP_FIN;
              end else begin
                state_nxt = fh64sm_pkg::ST_IDLE;
              end
            end
            fh64sm_pkg::OP_SQ: begin
              h_nxt = h_r ^ acc_r;
              go    = 1'b1;
              nop   = fh64sm_pkg::OP_MC;
            end
            fh64sm_pkg::OP_MC: begin
              h_nxt = acc_r;
              if (last_r) begin
                go  = 1'b1;
                nop = fh64sm_pkg::OP_FIN;
              end else begin
                state_nxt = fh64sm_pkg::ST_IDLE;
              end
            end
            fh64sm_pkg::OP_FIN: begin
              if (!out_tvalid_r || out_tready) begin
                out_tvalid_nxt = 1'b1;
                out_tdata_nxt  = acc_r;
                state_nxt      = fh64sm_pkg::ST_IDLE;
              end
            end
            default: begin
              state_nxt = fh64sm_pkg::ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = fh64sm_pkg::ST_IDLE;
      end
    endcase

    if (go) begin
      state_nxt = fh64sm_pkg::ST_MUL;
      op_nxt    = nop;
      acc_nxt   = 64'd0;
      case (nop)
        fh64sm_pkg::OP_LEN: begin
          a_nxt = fh64sm_pkg::HASH_MULT;
          b_nxt = 64'(in_len);
        end
        fh64sm_pkg::OP_SQ: begin
          a_nxt = sq_src;
          b_nxt = sq_src;
        end
        fh64sm_pkg::OP_MC: begin
          a_nxt = h_nxt;
          b_nxt = fh64sm_pkg::HASH_MULT;
        end
        fh64sm_pkg::OP_FIN: begin
          a_nxt = h_nxt;
          b_nxt = h_nxt;
        end
        default: begin
          a_nxt = 64'd0;
          b_nxt = 64'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fh64sm_pkg::ST_IDLE;
      op_r         <= fh64sm_pkg::OP_LEN;
      h_r          <= 64'd0;
      seed_r       <= 64'd0;
      mix_r        <= 1'b0;
      last_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      h_r          <= h_nxt;
      mix_r        <= mix_nxt;
      last_r       <= last_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    acc_r       <= acc_nxt;
    v_r         <= v_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // a request that mixes, starts or ends a key must occupy the multiplier
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser || in_tlast || (in_count != 4'd0)))
      |=> (state_r == fh64sm_pkg::ST_MUL))
    else $error("work request did not start the multiplier");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r)
      |-> $past(state_r == fh64sm_pkg::ST_MUL && op_r == fh64sm_pkg::OP_FIN && b_r == 64'd0))
    else $error("result raised outside final square");

  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fh64sm_pkg::ST_MUL && b_r != 64'd0)
      |=> (b_r == ($past(b_r) >> fh64sm_pkg::DIGIT_W)))
    else $error("multiplier digit shift lost");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fh64sm_pkg::ST_MUL && op_r == fh64sm_pkg::OP_FIN && b_r == 64'd0
      && out_tvalid_r && !out_tready)
      |=> (state_r == fh64sm_pkg::ST_MUL && $stable(acc_r)))
    else $error("final hash dropped while output busy");

endmodule

// File: tb/fasthash64_squared_mix_unit_tb.sv
// Testbench: squared-mix key hash unit, directed and random keys checked against a predictor.
`timescale 1ns / 1ps

module fasthash64_squared_mix_unit_tb;

  localparam int SETTLE_CYCLES = 60;  // longest word plus final square, with margin
  localparam int PHASE_ITEMS   = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;   // data_word[63:0], byte_count[67:64], key_length[83:68]
  logic        in_tuser = 1'b0; // first_word
  logic        in_tlast = 1'b0; // last_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // hash_value[63:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  logic [63:0] model_seed = '0;
  logic [63:0] model_hash = '0;
  logic [63:0] pending_hashes[$];
  int          errors = 0;
  bit          steady = 1'b0;   // no idling on either side while set

  fasthash64_squared_mix_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        if (out_tdata !== pending_hashes[0]) begin
          $display("%0t: hash mismatch, expected %h, actual %h",
                   $time, pending_hashes[0], out_tdata);
          errors++;
        end
        void'(pending_hashes.pop_front());
      end
    end
  end

  // Fold one accepted request into the running hash; a last word yields the squared hash.
  function automatic void fold_word(logic [63:0] word, logic [3:0] cnt, bit fst, bit lst,
                                    logic [15:0] len);
    logic [63:0] h;
    logic [63:0] v;
    h = model_hash;
    if (fst) h = model_seed ^ (64'(len) * fh64sm_pkg::HASH_MULT);
    if (cnt != 0) begin
      v = (cnt >= fh64sm_pkg::WORD_BYTES) ? word : word & ((64'd1 << (8 * cnt)) - 64'd1);
      h = h ^ (v * v);
      h = h * fh64sm_pkg::HASH_MULT;
    end
    model_hash = h;
    if (lst) pending_hashes.push_back(h * h);
  endfunction

  task automatic send_word(input logic [63:0] word, input logic [3:0] cnt, input bit fst,
                           input bit lst, input logic [15:0] len);
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, len, cnt, word};
    in_tuser  <= fst;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_word(word, cnt, fst, lst, len);
  endtask

  // Hold off until every hash is out and the block has gone quiet.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] seed);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= seed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_seed = seed;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Continues from the zero running hash.
  task automatic test_no_first_after_reset;
    send_word(rand_word(), 4'd8, 1'b0, 1'b1, 16'd0);
  endtask

  task automatic test_empty_keys;
    send_word(rand_word(), 4'd0, 1'b1, 1'b1, 16'd0);
    send_word(rand_word(), 4'd0, 1'b1, 1'b1, 16'hFFFF);
  endtask

  // Every byte count, including the saturating ones above eight.
  task automatic test_byte_counts;
    for (int c = 0; c < 16; c++) send_word('1, 4'(c), 1'b1, 1'b1, 16'(c));
  endtask

  task automatic test_key_marks;
    send_word('1, 4'd8, 1'b1, 1'b1, 16'd1234);      // length not matching the counts
    send_word('0, 4'd3, 1'b1, 1'b1, 16'd3);
    send_word(rand_word(), 4'd8, 1'b1, 1'b0, 16'd13);
    send_word(rand_word(), 4'd0, 1'b0, 1'b0, 16'd0); // mixes nothing mid-key
    send_word(rand_word(), 4'd5, 1'b0, 1'b1, 16'd0);
    send_word(rand_word(), 4'd7, 1'b0, 1'b1, 16'd0); // no first mark after a finished key
  endtask

  task automatic send_random_key(output int sent);
    int          nwords;
    int          tail;
    logic [15:0] len;
    logic [3:0]  cnt;
    nwords = $urandom_range(1, 4);
    tail   = $urandom_range(1, 8);
    len    = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'(8 * (nwords - 1) + tail);
    for (int i = 0; i < nwords; i++) begin
      cnt = (i == nwords - 1) ? 4'(tail) : 4'd8;
      if ($urandom_range(0, 9) == 0) cnt = 4'($urandom_range(0, 15));
      send_word(rand_word(), cnt, i == 0, i == nwords - 1, len);
    end
    sent = nwords;
  endtask

  task automatic test_random_keys(input logic [63:0] seed, input bit no_idle);
    int count;
    int sent;
    write_seed(seed);
    steady = no_idle;
    count = 0;
    while (count < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        send_random_key(sent);
        count += sent;
      end else begin
        send_word(rand_word(), 4'($urandom_range(0, 15)), 1'($urandom()), 1'($urandom()),
                  16'($urandom()));
        count++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_first_after_reset();
    test_empty_keys();
    test_byte_counts();
    test_key_marks();
    test_random_keys('1, 1'b0);
    test_random_keys(rand_word(), 1'b1);
    test_random_keys(64'h8000_0000_0000_0001, 1'b0);
    test_random_keys('0, 1'b0);
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
design/fh64sm_pkg.sv
design/fasthash64_squared_mix_unit.sv
tb/fasthash64_squared_mix_unit_tb.sv
